FILE: rtl/core/mkc_pkg.sv
// Package for the k-mer count model: command codes and shared constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mkc_pkg;
  localparam logic [2:0] CMD_PUSH  = 3'd0;
  localparam logic [2:0] CMD_INCR  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_QUERY = 3'd4;
  localparam logic [2:0] CMD_GEN   = 3'd5;
  localparam logic [0:0] REG_ORDER = 1'd0;
  localparam logic [0:0] REG_ALPHA = 1'd1;
  localparam int COUNT_BITS = 32;
endpackage
`default_nettype wire

FILE: rtl/core/mkc_if.sv
// Valid/ready channel interfaces for the k-mer count model.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface mkc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [1:0]  symbol;
  logic [7:0]  context_symbols;
  logic [31:0] write_value;
  logic [15:0] random_fraction;
  modport source (output valid, command, symbol, context_symbols, write_value,
                  random_fraction, input ready);
  modport sink (input valid, command, symbol, context_symbols, write_value,
                random_fraction, output ready);
endinterface

interface mkc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] count_value;
  logic [16:0] probability;
  logic [1:0]  generated_symbol;
  logic        symbol_error;
  modport source (output valid, count_value, probability, generated_symbol,
                  symbol_error, input ready);
  modport sink (input valid, count_value, probability, generated_symbol,
                symbol_error, output ready);
endinterface

interface mkc_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [2:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mkc_ram.sv
// Generic single-port RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mkc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  addr,
  input  wire [WIDTH-1:0]          wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/markov_kmer_count_model.sv
// Top level of the k-mer count model: sequencer, count RAM, serial divider.
// Depends on mkc_pkg, mkc_if, mkc_ram.
`timescale 1ns / 1ps
`default_nettype none
// One item at a time. After reset a clearing pass writes zero to all 1024
// count entries before the first item is taken; config writes are taken
// throughout. Push and write go straight to the result; read waits for the
// registered RAM data; increment reads, modifies and writes back through the
// single RAM port. Query reads the alphabet's counts one per cycle, then runs
// the bit-serial divider, which stops early with 0.25 when the context has no
// counts; a bad symbol goes straight to the result. Generate runs the divider
// once per symbol tried.
// The result register frees the sequencer once the result is taken.
module markov_kmer_count_model (
  input wire clk,
  input wire rst_n,
  mkc_in_if.sink    in_ch,
  mkc_out_if.source out_ch,
  mkc_cfg_if.sink   cfg_ch
);
  import mkc_pkg::*;
  localparam int AW = 10;
  localparam int FB = 16;
  localparam int SW = COUNT_BITS + 2;  // sum of four counts
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_RDW = 4'd3,
    S_MOD = 4'd4, S_SUM = 4'd5, S_DIV = 4'd6, S_CUM = 4'd7, S_OUT = 4'd8,
    S_PSEL = 4'd9;

  logic [3:0] st_r, st_nxt;
  logic [2:0] order_r, alpha_r;
  logic [AW-1:0] hist_r, clr_r;
  logic [2:0] cmd_r;
  logic [1:0] sym_r;
  logic [7:0] ctx_r;
  logic [COUNT_BITS-1:0] wval_r;
  logic [15:0] rnd_r;
  logic [2:0] k_r;           // read index over symbols
  logic [SW-1:0] sum_r;
  logic [COUNT_BITS-1:0] c_r;
  logic [SW:0] rem_r;
  logic [FB:0] q_r;
  logic [4:0] dcnt_r;
  logic [1:0] gk_r;          // generate: symbol under test
  logic [FB+2:0] cum_r;
  logic ov_r;
  logic [31:0] o_cnt_r;
  logic [16:0] o_prob_r;
  logic [1:0] o_gen_r;
  logic o_err_r;

  // effective config
  logic [2:0] eo;
  logic [2:0] ea;
  assign eo = (order_r > 3'd4) ? 3'd4 : order_r;
  assign ea = (alpha_r == 3'd0) ? 3'd1 : ((alpha_r > 3'd4) ? 3'd4 : alpha_r);

  // masks
  logic [AW-1:0] hmask, cmask;
  always_comb begin
    hmask = '0;
    cmask = '0;
    for (int i = 0; i < 5; i++) begin
      if (i < 32'(eo) + 1) hmask[2*i +: 2] = 2'b11;
      if (i < 32'(eo)) cmask[2*i +: 2] = 2'b11;
    end
  end

  logic [AW-1:0] hidx, qctx, qbase;
  assign hidx = hist_r & hmask;
  assign qctx = (cmd_r == CMD_GEN) ? (hist_r & cmask) : ({2'b00, ctx_r} & cmask);
  assign qbase = {qctx[AW-3:0], 2'b00};

  // RAM port
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [COUNT_BITS-1:0] ram_wd, ram_rd;
  mkc_ram #(.WIDTH(COUNT_BITS), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  logic acc;
  assign in_ch.ready = (st_r == S_IDLE);
  assign acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.count_value = o_cnt_r;
  assign out_ch.probability = o_prob_r;
  assign out_ch.generated_symbol = o_gen_r;
  assign out_ch.symbol_error = o_err_r;

  // target symbol for division
  logic [1:0] tsym;
  assign tsym = (cmd_r == CMD_GEN) ? gk_r : sym_r;
  logic [SW:0] rsh;
  assign rsh = {rem_r[SW-1:0], 1'b0};
  logic [FB+2:0] rscaled, cum_add;
  assign rscaled = {3'b000, rnd_r};
  assign cum_add = cum_r + {2'b00, q_r};

  always_comb begin
    st_nxt = st_r;
    ram_we = 1'b0;
    ram_addr = hidx;
    ram_wd = '0;
    unique case (st_r)
      S_CLR: begin
        ram_we = 1'b1; ram_addr = clr_r;
        if (clr_r == '1) st_nxt = S_IDLE;
      end
      S_IDLE: if (acc) st_nxt = S_PSEL;
      S_PSEL: begin
        priority if (cmd_r == CMD_PUSH || cmd_r > CMD_GEN) st_nxt = S_OUT;
        else if (cmd_r == CMD_WRITE) begin
          ram_we = 1'b1; ram_wd = wval_r; st_nxt = S_OUT;
        end else if (cmd_r == CMD_QUERY && {1'b0, sym_r} >= ea) st_nxt = S_OUT;
        else if (cmd_r == CMD_QUERY || cmd_r == CMD_GEN) st_nxt = S_SUM;
        else st_nxt = S_RD;
      end
      S_RD: st_nxt = S_RDW;
      S_RDW: st_nxt = (cmd_r == CMD_INCR) ? S_MOD : S_OUT;
      S_MOD: begin
        ram_we = 1'b1;
        ram_wd = (ram_rd == '1) ? ram_rd : ram_rd + COUNT_BITS'(1);
        st_nxt = S_OUT;
      end
      S_SUM: begin
        // address k_r issued; data for k_r-1 arrives
        ram_addr = qbase | {8'd0, k_r[1:0]};
        if (k_r == ea) st_nxt = S_DIV;
      end
      S_DIV: if (dcnt_r == 5'd0) st_nxt = (cmd_r == CMD_GEN) ? S_CUM : S_OUT;
      S_CUM: begin
        if (rscaled < cum_add || {1'b0, gk_r} == ea - 3'd1) st_nxt = S_OUT;
        else st_nxt = S_DIV;
      end
      S_OUT: if (out_ch.ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; hist_r <= '0;
      order_r <= 3'd0; alpha_r <= 3'd4;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (cfg_ch.valid) begin
        if (cfg_ch.index == REG_ORDER) order_r <= cfg_ch.data;
        else alpha_r <= cfg_ch.data;
      end
      if (st_r == S_PSEL && cmd_r == CMD_PUSH && {1'b0, sym_r} < ea)
        hist_r <= {hist_r[AW-3:0], sym_r};
      if (st_r == S_CUM && st_nxt == S_OUT) hist_r <= {hist_r[AW-3:0], gk_r};
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r <= in_ch.command; sym_r <= in_ch.symbol; ctx_r <= in_ch.context_symbols;
      wval_r <= in_ch.write_value[COUNT_BITS-1:0]; rnd_r <= in_ch.random_fraction;
      o_cnt_r <= '0; o_prob_r <= '0; o_gen_r <= '0; o_err_r <= 1'b0;
      gk_r <= '0; cum_r <= '0;
    end
    if (st_r == S_PSEL) begin
      k_r <= '0; sum_r <= '0; c_r <= '0;
      if ((cmd_r == CMD_PUSH || cmd_r == CMD_QUERY) && {1'b0, sym_r} >= ea)
        o_err_r <= 1'b1;
    end
    if (st_r == S_RDW && cmd_r == CMD_READ) o_cnt_r <= 32'(ram_rd);
    if (st_r == S_SUM) begin
      k_r <= k_r + 1'b1;
      if (k_r != 3'd0) begin
        sum_r <= sum_r + SW'(ram_rd);
        if (k_r[1:0] - 2'd1 == tsym && k_r <= 3'd4) c_r <= ram_rd;
      end
      if (k_r == ea) begin
        dcnt_r <= 5'd17;
        q_r <= '0;
        ov_r <= 1'b0;
      end
    end
    // Sum and numerator are complete on entry; load the numerator first.
    if (st_r == S_DIV) begin
      if (dcnt_r == 5'd17) begin
        rem_r <= (SW+1)'(c_r);
        dcnt_r <= 5'd16;
        ov_r <= 1'b0;
      end else if (dcnt_r == 5'd16 && !ov_r) begin
        ov_r <= 1'b1;
        if (sum_r == '0) begin q_r <= 17'(1 << (FB-2)); dcnt_r <= 5'd0; end
        else if (rem_r >= {1'b0, sum_r}) begin q_r <= 17'(1 << FB); dcnt_r <= 5'd0; end
      end else if (dcnt_r != 5'd0) begin
        dcnt_r <= dcnt_r - 1'b1;
        if (rsh >= {1'b0, sum_r}) begin
          rem_r <= rsh - {1'b0, sum_r}; q_r <= {q_r[FB-1:0], 1'b1};
        end else begin
          rem_r <= rsh; q_r <= {q_r[FB-1:0], 1'b0};
        end
      end
      if (dcnt_r == 5'd0 && cmd_r == CMD_QUERY) o_prob_r <= q_r;
    end
    if (st_r == S_CUM) begin
      cum_r <= cum_add;
      if (st_nxt == S_OUT) o_gen_r <= gk_r;
      else begin
        gk_r <= gk_r + 1'b1;
        // rerun divider for the next symbol; sum is unchanged
        dcnt_r <= 5'd16; ov_r <= 1'b0; q_r <= '0;
        rem_r <= (SW+1)'(cv_r[gk_r + 2'd1]);
      end
    end
  end

  // Numerator for next generate symbol is not refetched from the RAM: counts are kept
  // in a small side register file filled during the sum pass.
  logic [COUNT_BITS-1:0] cv_r [4];
  always_ff @(posedge clk) begin
    if (st_r == S_SUM && k_r != 3'd0) cv_r[k_r[1:0] - 2'd1] <= ram_rd;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("accept while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> o_prob_r <= 17'(1 << FB)) else $error("probability above one");
endmodule
`default_nettype wire

FILE: tb/markov_kmer_count_model_tb.sv
// Self-checking testbench for markov_kmer_count_model: directed and random
// commands checked against an in-bench count-table predictor.
// Depends on mkc_pkg, mkc_if and the RTL top level.
`timescale 1ns / 1ps
module markov_kmer_count_model_tb;
  import mkc_pkg::*;

  // Command codes outside the defined set; the block must ignore them.
  localparam logic [2:0] CMD_UNUSED6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED7 = 3'd7;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 200;
  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic [31:0] count_value;
    logic [16:0] probability;
    logic [1:0]  generated_symbol;
    logic        symbol_error;
  } kmer_result_t;

  logic clk = 1'b0;
  logic rst_n;

  mkc_in_if  in_bus ();
  mkc_out_if out_bus ();
  mkc_cfg_if cfg_bus ();

  markov_kmer_count_model dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: count table, symbol history and the two registers.
  logic [31:0] count_tbl [1024];
  logic [9:0]  sym_hist;
  logic [2:0]  order_reg;
  logic [2:0]  alpha_reg;

  // Expected beats, written by the sender, read by the checker.
  kmer_result_t exp_q [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int mismatches = 0;
  int cycles = 0;

  // Sender burst control; idle_on = 0 gives back-to-back beats.
  int burst_left = 0;
  bit idle_on = 1'b1;
  // Receiver stall pattern: 0 never stalls, 1 random, 2 periodic.
  int stall_mode = 0;

  function automatic int exp_level();
    return exp_wr - exp_rd;
  endfunction

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic [9:0] sym_mask(int n);
    if (n >= 5) return 10'h3FF;
    return 10'((1 << (2 * n)) - 1);
  endfunction

  function automatic int eff_order();
    return (order_reg > 3'd4) ? 4 : int'(order_reg);
  endfunction

  function automatic int eff_alpha();
    if (alpha_reg == 3'd0) return 1;
    if (alpha_reg > 3'd4) return 4;
    return int'(alpha_reg);
  endfunction

  // floor(c * 2^16 / sum) in Q1.16, 0.25 when the context has no counts
  function automatic logic [16:0] cond_prob(logic [9:0] ctx, int s);
    logic [9:0]  base;
    logic [35:0] total;
    logic [35:0] num;
    logic [35:0] rem;
    logic [16:0] q;
    base = {ctx[7:0], 2'b00};
    total = '0;
    num = '0;
    for (int k = 0; k < eff_alpha(); k++) begin
      total += count_tbl[base | 10'(k)];
      if (k == s) num = count_tbl[base | 10'(k)];
    end
    if (total == 0) return 17'h04000;
    if (num >= total) return 17'h10000;
    rem = num;
    q = '0;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= total) begin
        rem -= total;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  task automatic predict_item(input logic [2:0] cmd, input logic [1:0] sym,
                              input logic [7:0] ctx, input logic [31:0] wval,
                              input logic [15:0] rnd, output kmer_result_t res);
    int o;
    int a;
    logic [9:0]  hidx;
    logic [17:0] cum;
    int pick;
    o = eff_order();
    a = eff_alpha();
    hidx = sym_hist & sym_mask(o + 1);
    res = '0;
    case (cmd)
      CMD_PUSH: begin
        if (sym >= a) res.symbol_error = 1'b1;
        else sym_hist = {sym_hist[7:0], sym};
      end
      CMD_INCR: begin
        if (count_tbl[hidx] != 32'hFFFF_FFFF) count_tbl[hidx]++;
      end
      CMD_WRITE: count_tbl[hidx] = wval;
      CMD_READ:  res.count_value = count_tbl[hidx];
      CMD_QUERY: begin
        if (sym >= a) res.symbol_error = 1'b1;
        else res.probability = cond_prob({2'b00, ctx} & sym_mask(o), int'(sym));
      end
      CMD_GEN: begin
        cum = '0;
        pick = a - 1;
        for (int k = 0; k < a; k++) begin
          cum += cond_prob(sym_hist & sym_mask(o), k);
          if ({2'b00, rnd} < cum) begin
            pick = k;
            break;
          end
        end
        sym_hist = {sym_hist[7:0], 2'(pick)};
        res.generated_symbol = 2'(pick);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Result checker: compare each accepted beat with the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    kmer_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (exp_level() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: cnt=%h prob=%h gen=%0d err=%0b",
                   out_bus.count_value, out_bus.probability,
                   out_bus.generated_symbol, out_bus.symbol_error);
      end else begin
        want = exp_q[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_bus.count_value !== want.count_value ||
            out_bus.probability !== want.probability ||
            out_bus.generated_symbol !== want.generated_symbol ||
            out_bus.symbol_error !== want.symbol_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%h/%0d/%0b got %h/%h/%0d/%0b",
                     want.count_value, want.probability, want.generated_symbol,
                     want.symbol_error, out_bus.count_value, out_bus.probability,
                     out_bus.generated_symbol, out_bus.symbol_error);
        end
      end
    end
    // receiver backpressure
    case (stall_mode)
      0: out_bus.ready <= 1'b1;
      1: out_bus.ready <= ($urandom_range(0, 9) < 7);
      default: out_bus.ready <= ((cycles % 7) > 2);
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("markov_kmer_count_model_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  task automatic send_item(input logic [2:0] cmd, input logic [1:0] sym,
                           input logic [7:0] ctx, input logic [31:0] wval,
                           input logic [15:0] rnd);
    kmer_result_t res;
    int gap;
    if (idle_on && burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    in_bus.valid <= 1'b1;
    in_bus.command <= cmd;
    in_bus.symbol <= sym;
    in_bus.context_symbols <= ctx;
    in_bus.write_value <= wval;
    in_bus.random_fraction <= rnd;
    do @(posedge clk); while (!in_bus.ready);
    predict_item(cmd, sym, ctx, wval, rnd, res);
    exp_q[exp_wr % EXP_DEPTH] = res;
    exp_wr++;
  endtask

  // Hold off the sender until every expected beat has been taken.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (exp_level() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [2:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == REG_ORDER) order_reg = val;
    else alpha_reg = val;
  endtask

  task automatic set_model(input logic [2:0] ord, input logic [2:0] alpha);
    drain_results();
    write_reg(REG_ORDER, ord);
    write_reg(REG_ALPHA, alpha);
    cfg_bus.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Extremes, every command, saturation, empty context, bad symbols,
  // unused commands and out-of-range register values.
  task automatic test_directed();
    stall_mode = 0;
    idle_on = 1'b0;
    send_item(CMD_QUERY, 2'd2, 8'h00, '0, '0);            // empty context: 0.25
    send_item(CMD_PUSH, 2'd3, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(CMD_WRITE, 2'd0, 8'h00, 32'hFFFF_FFFF, '0);
    send_item(CMD_INCR, 2'd0, 8'h00, '0, '0);             // saturates
    send_item(CMD_READ, 2'd0, 8'h00, '0, '0);
    send_item(CMD_PUSH, 2'd1, 8'h00, '0, '0);
    send_item(CMD_INCR, 2'd0, 8'h00, '0, '0);
    send_item(CMD_QUERY, 2'd3, 8'hAA, '0, '0);            // just below full probability
    send_item(CMD_QUERY, 2'd1, 8'h55, '0, '0);
    send_item(CMD_GEN, 2'd0, 8'h00, '0, 16'h0000);
    send_item(CMD_GEN, 2'd0, 8'h00, '0, 16'hFFFF);
    send_item(CMD_UNUSED6, 2'd3, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(CMD_UNUSED7, 2'd3, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    set_model(3'd7, 3'd2);                                // order clamps, alpha 2
    send_item(CMD_PUSH, 2'd3, 8'h00, '0, '0);             // bad push symbol
    send_item(CMD_QUERY, 2'd2, 8'hFF, '0, '0);            // bad query symbol
    send_item(CMD_WRITE, 2'd0, 8'h00, 32'h0000_0005, '0);
    send_item(CMD_GEN, 2'd0, 8'h00, '0, 16'hFFFF);        // falls to last symbol
    set_model(3'd5, 3'd0);                                // alpha 0 acts as 1
    send_item(CMD_PUSH, 2'd1, 8'h00, '0, '0);
    send_item(CMD_GEN, 2'd0, 8'h00, '0, 16'h8000);
    set_model(3'd4, 3'd7);                                // alpha clamps to 4
    send_item(CMD_QUERY, 2'd3, 8'hE4, '0, '0);
    send_item(CMD_READ, 2'd0, 8'h00, '0, '0);
  endtask

  // Random traffic under one setting: pushes and increments (half the items)
  // build counts along the history, mixed with writes, reads, queries and generates.
  task automatic test_random_traffic(input logic [2:0] ord, input logic [2:0] alpha,
                                     input int n_items, input int stalls,
                                     input bit idles);
    int a;
    int pick;
    logic [2:0]  cmd;
    logic [1:0]  sym;
    logic [31:0] wval;
    set_model(ord, alpha);
    stall_mode = stalls;
    idle_on = idles;
    a = eff_alpha();
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25)      cmd = CMD_PUSH;
      else if (pick < 50) cmd = CMD_INCR;
      else if (pick < 58) cmd = CMD_WRITE;
      else if (pick < 68) cmd = CMD_READ;
      else if (pick < 83) cmd = CMD_QUERY;
      else if (pick < 97) cmd = CMD_GEN;
      else cmd = $urandom_range(0, 1) ? CMD_UNUSED6 : CMD_UNUSED7;
      sym = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                        : 2'($urandom_range(0, a - 1));
      case ($urandom_range(0, 3))
        0: wval = $urandom;
        1: wval = 32'hFFFF_FFFF - $urandom_range(0, 2);
        default: wval = $urandom_range(0, 20);
      endcase
      send_item(cmd, sym, 8'($urandom), wval, 16'($urandom));
    end
  endtask

  // Sender stops mid-stream until all results are back, then resumes.
  task automatic test_full_drain();
    test_random_traffic(3'd2, 3'd4, 40, 1, 1'b1);
    drain_results();
    test_random_traffic(3'd2, 3'd4, 40, 2, 1'b1);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.command <= CMD_PUSH;
    in_bus.symbol <= '0;
    in_bus.context_symbols <= '0;
    in_bus.write_value <= '0;
    in_bus.random_fraction <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_ORDER;
    cfg_bus.data <= '0;
    foreach (count_tbl[i]) count_tbl[i] = '0;
    sym_hist = '0;
    order_reg = 3'd0;
    alpha_reg = 3'd4;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(3'd0, 3'd4, 150, 0, 1'b0);
    test_random_traffic(3'd1, 3'd4, 150, 1, 1'b1);
    test_random_traffic(3'd2, 3'd3, 150, 2, 1'b1);
    test_full_drain();
    test_random_traffic(3'd4, 3'd4, 150, 1, 1'b1);
    test_random_traffic(3'd7, 3'd2, 120, 0, 1'b1);
    test_random_traffic(3'd3, 3'd1, 100, 2, 1'b0);
    test_random_traffic(3'd6, 3'd0, 60, 1, 1'b1);
    test_random_traffic(3'd1, 3'd7, 100, 1, 1'b1);
    test_random_traffic(3'd0, 3'd2, 90, 2, 1'b1);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && exp_level() == 0) begin
      $display("markov_kmer_count_model_tb: clean");
    end else begin
      $display("markov_kmer_count_model_tb: errors");
    end
    $finish;
  end
endmodule
